@@ rtl/fbfl_pkg.sv @@
// shared types and constants of the fixed block free list allocator
package fbfl_pkg;

  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = $clog2(NUM_BLOCKS);
  localparam int LINK_W     = $clog2(NUM_BLOCKS + 1);
  localparam int OFF_W      = 20;
  localparam int POOL_W     = 21;
  localparam int SHIFT_W    = 4;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [LINK_W-1:0]  NULL_LINK   = LINK_W'(NUM_BLOCKS);
  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = 4'd3;
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = 4'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_RST   = 4'd6;
  localparam logic [POOL_W-1:0]  POOL_RST    = 21'd65536;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_INIT  = 2'd2;

  localparam logic REG_BLOCK_SHIFT = 1'b0;
  localparam logic REG_POOL_BYTES  = 1'b1;

  typedef struct packed {
    logic [1:0]       mode;
    logic [OFF_W-1:0] block_offset;
  } in_item_t;

  typedef struct packed {
    logic [OFF_W-1:0] result_offset;
    logic             status;
  } out_item_t;

  typedef struct packed {
    logic [SHIFT_W-1:0] shift;
    logic [POOL_W-1:0]  pool_bytes;
  } cfg_t;

endpackage

@@ rtl/fbfl_cfg.sv @@
// configuration registers on the apb port, with the clamped block shift
module fbfl_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [fbfl_pkg::ADDR_W-1:0] paddr,
  input  logic [fbfl_pkg::DATA_W-1:0] pwdata,
  output logic [fbfl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output fbfl_pkg::cfg_t             cfg_o
);

  logic [fbfl_pkg::SHIFT_W-1:0] block_shift_q;
  logic [fbfl_pkg::POOL_W-1:0]  pool_bytes_q;
  logic                         wr_en;
  logic                         reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_shift_q <= fbfl_pkg::SHIFT_RST;
      pool_bytes_q  <= fbfl_pkg::POOL_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        fbfl_pkg::REG_BLOCK_SHIFT: block_shift_q <= pwdata[fbfl_pkg::SHIFT_W-1:0];
        fbfl_pkg::REG_POOL_BYTES:  pool_bytes_q  <= pwdata[fbfl_pkg::POOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fbfl_pkg::REG_BLOCK_SHIFT:
        prdata = fbfl_pkg::DATA_W'(block_shift_q);
      fbfl_pkg::REG_POOL_BYTES:
        prdata = fbfl_pkg::DATA_W'(pool_bytes_q);
      default: prdata = '0;
    endcase
  end

  // shift outside the supported block sizes is pinned to the nearest end
  always_comb begin
    priority if (block_shift_q < fbfl_pkg::SHIFT_MIN) begin
      cfg_o.shift = fbfl_pkg::SHIFT_MIN;
    end else if (block_shift_q > fbfl_pkg::SHIFT_MAX) begin
      cfg_o.shift = fbfl_pkg::SHIFT_MAX;
    end else begin
      cfg_o.shift = block_shift_q;
    end
    cfg_o.pool_bytes = pool_bytes_q;
  end

endmodule

@@ rtl/fixed_block_free_list_allocator.sv @@
// top level: free list head, next-link memory and the item sequencer
//
//  channel | direction | handshake          | payload
//  in      | input     | in_valid_i/stall_o | in_data_i  (mode, block_offset)
//  out     | output    | out_valid_o/stall_i| out_data_o (result_offset, status)
//  cfg     | input     | apb psel/penable   | block_shift, pool_bytes
//
// free, unused mode and allocate on an empty list finish from the idle state;
// allocate first reads the link memory, whose read is registered, and finishes in ST_ALLOC.
// initialize writes a link for each block of the pool in turn (up to NUM_BLOCKS).
// reset empties the list at once; the link memory is not cleared.
// a new item is taken while a result waits; a finished result that cannot
// leave is parked and holds off the input until the output register frees up.
module fixed_block_free_list_allocator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  fbfl_pkg::in_item_t          in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output fbfl_pkg::out_item_t         out_data_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fbfl_pkg::ADDR_W-1:0] paddr,
  input  logic [fbfl_pkg::DATA_W-1:0] pwdata,
  output logic [fbfl_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_INIT,
    ST_HOLD
  } state_e;

  fbfl_pkg::cfg_t cfg;

  fbfl_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  state_e                        state_q, state_d;
  logic [fbfl_pkg::LINK_W-1:0]   head_q, head_d;
  logic [fbfl_pkg::IDX_W-1:0]    cnt_q, cnt_d;
  logic [fbfl_pkg::LINK_W-1:0]   nb_q, nb_d;
  fbfl_pkg::out_item_t           hold_q, hold_d;
  logic                          out_valid_q;
  fbfl_pkg::out_item_t           out_q;

  // link memory
  logic [fbfl_pkg::LINK_W-1:0]   link_mem [fbfl_pkg::NUM_BLOCKS];
  logic [fbfl_pkg::LINK_W-1:0]   rdata_q;
  logic                          mem_we;
  logic [fbfl_pkg::IDX_W-1:0]    mem_waddr;
  logic [fbfl_pkg::LINK_W-1:0]   mem_wdata;
  logic                          mem_re;

  logic                          accept;
  logic                          out_free;
  logic                          fin;
  fbfl_pkg::out_item_t           res;
  logic                          load;
  fbfl_pkg::out_item_t           load_data;
  logic [fbfl_pkg::OFF_W-1:0]    free_blk;
  logic [fbfl_pkg::POOL_W-1:0]   nb_raw;
  logic [fbfl_pkg::LINK_W-1:0]   nb_sat;
  logic [fbfl_pkg::OFF_W-1:0]    alloc_off;
  logic [fbfl_pkg::LINK_W-1:0]   cnt_next;
  logic                          init_last;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign free_blk  = in_data_i.block_offset >> cfg.shift;
  assign nb_raw    = cfg.pool_bytes >> cfg.shift;
  assign nb_sat    = (nb_raw > fbfl_pkg::POOL_W'(fbfl_pkg::NUM_BLOCKS)) ?
                     fbfl_pkg::NULL_LINK : nb_raw[fbfl_pkg::LINK_W-1:0];
  assign alloc_off = fbfl_pkg::OFF_W'(head_q[fbfl_pkg::IDX_W-1:0]) << cfg.shift;
  assign cnt_next  = fbfl_pkg::LINK_W'(cnt_q) + fbfl_pkg::LINK_W'(1);
  assign init_last = (cnt_next == nb_q);

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    cnt_d     = cnt_q;
    nb_d      = nb_q;
    hold_d    = hold_q;
    fin       = 1'b0;
    res       = '0;
    load      = 1'b0;
    load_data = hold_q;
    mem_we    = 1'b0;
    mem_waddr = cnt_q;
    mem_wdata = head_q;
    mem_re    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_data_i.mode)
            fbfl_pkg::MODE_ALLOC: begin
              if (head_q == fbfl_pkg::NULL_LINK) begin
                res.status = 1'b1;
                fin        = 1'b1;
              end else begin
                mem_re  = 1'b1;
                state_d = ST_ALLOC;
              end
            end
            fbfl_pkg::MODE_FREE: begin
              // blocks past the table are dropped silently
              if (free_blk < fbfl_pkg::OFF_W'(fbfl_pkg::NUM_BLOCKS)) begin
                mem_we    = 1'b1;
                mem_waddr = free_blk[fbfl_pkg::IDX_W-1:0];
                mem_wdata = head_q;
                head_d    = fbfl_pkg::LINK_W'(free_blk[fbfl_pkg::IDX_W-1:0]);
              end
              fin = 1'b1;
            end
            fbfl_pkg::MODE_INIT: begin
              if (nb_sat == '0) begin
                head_d = fbfl_pkg::NULL_LINK;
                fin    = 1'b1;
              end else begin
                nb_d    = nb_sat;
                cnt_d   = '0;
                state_d = ST_INIT;
              end
            end
            default: fin = 1'b1;
          endcase
        end
      end
      ST_ALLOC: begin
        res.result_offset = alloc_off;
        head_d            = rdata_q;
        fin               = 1'b1;
      end
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_q;
        mem_wdata = init_last ? fbfl_pkg::NULL_LINK : cnt_next;
        cnt_d     = cnt_next[fbfl_pkg::IDX_W-1:0];
        if (init_last) begin
          head_d = '0;
          fin    = 1'b1;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load      = 1'b1;
          load_data = hold_q;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (fin) begin
      if (out_free) begin
        load      = 1'b1;
        load_data = res;
        state_d   = ST_IDLE;
      end else begin
        hold_d  = res;
        state_d = ST_HOLD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= fbfl_pkg::NULL_LINK;
      cnt_q       <= '0;
      nb_q        <= '0;
      hold_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      cnt_q   <= cnt_d;
      nb_q    <= nb_d;
      hold_q  <= hold_d;
      if (load) begin
        out_valid_q <= 1'b1;
        out_q       <= load_data;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      link_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= link_mem[head_q[fbfl_pkg::IDX_W-1:0]];
    end
  end

endmodule

@@ rtl/fbfl_chk.sv @@
// port-level checks for the allocator, bound to the top level
module fbfl_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input fbfl_pkg::in_item_t          in_data_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input fbfl_pkg::out_item_t         out_data_o,
  input logic                        pready
);

  // an exhausted allocate never carries an offset
  a_exhaust_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status |-> out_data_o.result_offset == '0)
    else $error("exhausted result with non-zero offset");

  // a waiting result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // every transfer in leaves the block busy or a result showing
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o || out_valid_o)
    else $error("accepted item vanished");

  // a free with room at the output shows its result in the next cycle
  a_free_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.mode == fbfl_pkg::MODE_FREE &&
    !(out_valid_o && out_stall_i) |=> out_valid_o && !out_data_o.status)
    else $error("free result missing");

  a_pready: assert property (@(posedge clk_i) pready)
    else $error("pready low");

endmodule

bind fixed_block_free_list_allocator fbfl_chk u_fbfl_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .pready      (pready)
);

@@ sim/tb_fixed_block_free_list_allocator.sv @@
// self-checking testbench for the fixed block free list allocator
module tb_fixed_block_free_list_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 400_000;
  localparam int DRAIN_CYCLES = 20;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  fbfl_pkg::in_item_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  fbfl_pkg::out_item_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [fbfl_pkg::ADDR_W-1:0] paddr = '0;
  logic [fbfl_pkg::DATA_W-1:0] pwdata = '0;
  logic [fbfl_pkg::DATA_W-1:0] prdata;
  logic pready;

  // free list as the testbench sees it
  logic [fbfl_pkg::LINK_W-1:0] link_tbl [fbfl_pkg::NUM_BLOCKS];
  logic [fbfl_pkg::LINK_W-1:0] head_idx = fbfl_pkg::NULL_LINK;
  logic [fbfl_pkg::SHIFT_W-1:0] cfg_shift = fbfl_pkg::SHIFT_RST;
  logic [fbfl_pkg::POOL_W-1:0] cfg_pool = fbfl_pkg::POOL_RST;
  logic [fbfl_pkg::OFF_W-1:0] owned_offsets [$];
  fbfl_pkg::out_item_t awaited_results [$];
  fbfl_pkg::out_item_t want;

  int error_count = 0;
  int cycle_count = 0;
  int rx_wait = 0;
  int hold_left = 0;
  bit no_gaps = 1'b0;

  fixed_block_free_list_allocator DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int unsigned eff_shift();
    if (cfg_shift < fbfl_pkg::SHIFT_MIN) return fbfl_pkg::SHIFT_MIN;
    if (cfg_shift > fbfl_pkg::SHIFT_MAX) return fbfl_pkg::SHIFT_MAX;
    return cfg_shift;
  endfunction

  // applies one request to the free list and returns the result it should give
  function automatic fbfl_pkg::out_item_t step_free_list(fbfl_pkg::in_item_t req);
    fbfl_pkg::out_item_t res;
    int unsigned sh;
    int unsigned blk;
    int unsigned nb;
    res = '0;
    sh = eff_shift();
    case (req.mode)
      fbfl_pkg::MODE_ALLOC: begin
        if (head_idx >= fbfl_pkg::NULL_LINK) begin
          res.status = 1'b1;
        end else begin
          blk = head_idx;
          res.result_offset = fbfl_pkg::OFF_W'(blk << sh);
          head_idx = link_tbl[blk];
          owned_offsets.push_back(res.result_offset);
        end
      end
      fbfl_pkg::MODE_FREE: begin
        blk = req.block_offset >> sh;
        // indices past the table are dropped silently
        if (blk < fbfl_pkg::NUM_BLOCKS) begin
          link_tbl[blk] = head_idx;
          head_idx = fbfl_pkg::LINK_W'(blk);
        end
      end
      fbfl_pkg::MODE_INIT: begin
        nb = cfg_pool >> sh;
        if (nb > fbfl_pkg::NUM_BLOCKS) nb = fbfl_pkg::NUM_BLOCKS;
        for (int i = 0; i < nb; i++) begin
          link_tbl[i] = (i + 1 < nb) ? fbfl_pkg::LINK_W'(i + 1) : fbfl_pkg::NULL_LINK;
        end
        head_idx = (nb > 0) ? '0 : fbfl_pkg::NULL_LINK;
        owned_offsets.delete();
      end
      default: ;
    endcase
    return res;
  endfunction

  // task starts and ends at a falling edge; valid stays high for a back-to-back transfer
  task automatic send_item(input logic [1:0] mode, input logic [fbfl_pkg::OFF_W-1:0] offset);
    int unsigned gap;
    fbfl_pkg::in_item_t req;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    req.mode = mode;
    req.block_offset = offset;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    awaited_results.push_back(step_free_list(req));
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (awaited_results.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic reg_idx, input logic [fbfl_pkg::DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= fbfl_pkg::ADDR_W'({reg_idx, 2'b00});
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (reg_idx == fbfl_pkg::REG_BLOCK_SHIFT) cfg_shift = value[fbfl_pkg::SHIFT_W-1:0];
    else cfg_pool = value[fbfl_pkg::POOL_W-1:0];
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  // mostly allocs and frees of blocks held, with some noise mixed in
  task automatic send_random_op();
    int unsigned pick;
    int unsigned idx;
    logic [fbfl_pkg::OFF_W-1:0] off;
    pick = $urandom_range(0, 99);
    if (pick < 45 || (pick < 90 && owned_offsets.size() == 0)) begin
      send_item(fbfl_pkg::MODE_ALLOC, fbfl_pkg::OFF_W'($urandom));
    end else if (pick < 85) begin
      idx = $urandom_range(0, owned_offsets.size() - 1);
      off = owned_offsets[idx];
      owned_offsets.delete(idx);
      if ($urandom_range(0, 7) == 0) begin
        off = off | fbfl_pkg::OFF_W'($urandom_range(0, (1 << eff_shift()) - 1));
      end
      send_item(fbfl_pkg::MODE_FREE, off);
    end else if (pick < 90) begin
      // block stays on the owned list, so it may be freed a second time later
      send_item(fbfl_pkg::MODE_FREE,
                owned_offsets[$urandom_range(0, owned_offsets.size() - 1)]);
    end else if (pick < 96) begin
      send_item(fbfl_pkg::MODE_FREE, fbfl_pkg::OFF_W'($urandom));
    end else if (pick < 98) begin
      send_item(MODE_UNUSED, fbfl_pkg::OFF_W'($urandom));
    end else begin
      send_item(fbfl_pkg::MODE_INIT, fbfl_pkg::OFF_W'($urandom));
    end
  endtask

  // at times stall after a result transfer, or through a long hold-off
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (rx_wait > 0) begin
      rx_wait--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got offset %h status %b",
                 $time, out_data_o.result_offset, out_data_o.status);
        error_count++;
      end else begin
        want = awaited_results.pop_front();
        if (out_data_o.result_offset !== want.result_offset) begin
          $display("%0t: result_offset mismatch, expected %h, got %h",
                   $time, want.result_offset, out_data_o.result_offset);
          error_count++;
        end
        if (out_data_o.status !== want.status) begin
          $display("%0t: status mismatch, expected %b, got %b",
                   $time, want.status, out_data_o.status);
          error_count++;
        end
      end
      rx_wait = no_gaps ? 0 : $urandom_range(0, 6);
    end
  end

  task automatic test_empty_list();
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(MODE_UNUSED, 20'hFFFFF);
    send_item(fbfl_pkg::MODE_FREE, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
  endtask

  task automatic test_default_pool();
    send_item(fbfl_pkg::MODE_INIT, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_FREE, 20'd77);
    send_item(fbfl_pkg::MODE_FREE, 20'hFFFFF);
    send_item(fbfl_pkg::MODE_FREE, '0);
    send_item(fbfl_pkg::MODE_FREE, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_FREE, 20'h0FFC0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
  endtask

  task automatic test_shift_limits();
    wait_drained();
    write_reg(fbfl_pkg::REG_BLOCK_SHIFT, 32'd0);
    write_reg(fbfl_pkg::REG_POOL_BYTES, 32'd30);
    send_item(fbfl_pkg::MODE_INIT, '0);
    repeat (4) send_item(fbfl_pkg::MODE_ALLOC, '0);
    wait_drained();
    write_reg(fbfl_pkg::REG_BLOCK_SHIFT, 32'd15);
    write_reg(fbfl_pkg::REG_POOL_BYTES, 32'd1048576);
    send_item(fbfl_pkg::MODE_INIT, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    send_item(fbfl_pkg::MODE_FREE, 20'hFFC00);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    wait_drained();
    // links keep their indices, offsets follow the new shift
    write_reg(fbfl_pkg::REG_BLOCK_SHIFT, 32'd3);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
    wait_drained();
    write_reg(fbfl_pkg::REG_POOL_BYTES, 32'd0);
    send_item(fbfl_pkg::MODE_INIT, '0);
    send_item(fbfl_pkg::MODE_ALLOC, '0);
  endtask

  task automatic test_back_pressure();
    wait_drained();
    write_reg(fbfl_pkg::REG_BLOCK_SHIFT, 32'd4);
    write_reg(fbfl_pkg::REG_POOL_BYTES, 32'd160);
    send_item(fbfl_pkg::MODE_INIT, '0);
    wait_drained();
    @(posedge clk_i);
    hold_left = 80;
    @(negedge clk_i);
    no_gaps = 1'b1;
    repeat (30) send_random_op();
    no_gaps = 1'b0;
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned sh;
    int unsigned eff;
    logic [fbfl_pkg::DATA_W-1:0] pool;
    repeat (13) begin
      wait_drained();
      sh = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(3, 10);
      eff = (sh < fbfl_pkg::SHIFT_MIN) ? fbfl_pkg::SHIFT_MIN :
            ((sh > fbfl_pkg::SHIFT_MAX) ? fbfl_pkg::SHIFT_MAX : sh);
      case ($urandom_range(0, 9))
        0: pool = '0;
        1: pool = 32'd1048576;
        2: pool = $urandom_range(0, 2097151);
        default: pool = ($urandom_range(1, 40) << eff) + $urandom_range(0, (1 << eff) - 1);
      endcase
      // upper data bits are junk that the registers must drop
      write_reg(fbfl_pkg::REG_BLOCK_SHIFT, ($urandom & 32'hFFFF_FFF0) | sh);
      write_reg(fbfl_pkg::REG_POOL_BYTES, ($urandom & 32'hFFE0_0000) | pool);
      no_gaps = ($urandom_range(0, 3) == 0);
      send_item(fbfl_pkg::MODE_INIT, fbfl_pkg::OFF_W'($urandom));
      repeat ($urandom_range(40, 50)) send_random_op();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_empty_list();
    test_default_pool();
    test_shift_limits();
    test_back_pressure();
    test_random_traffic();
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (awaited_results.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fbfl_pkg.sv
rtl/fbfl_cfg.sv
rtl/fixed_block_free_list_allocator.sv
rtl/fbfl_chk.sv
sim/tb_fixed_block_free_list_allocator.sv
